@@ src/gqpe_pkg.sv @@
`default_nettype none

package gqpe_pkg;

  localparam int MAX_VARS_DEF = 32;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_ADD   = 2'd1,
    REQ_EVAL  = 2'd2,
    REQ_SUB   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ADD,
    S_RUN,
    S_DONE
  } state_t;

  typedef struct packed {
    req_t        req_type;
    logic [4:0]  row_index;
    logic [31:0] row_bits;
    logic        const_bit;
    logic [6:0]  var_count;
    logic [31:0] point;
    logic [5:0]  sub_count;
  } req_item_t;

  typedef struct packed {
    logic       eval_value;
    logic [5:0] active_vars;
  } rsp_item_t;

endpackage

`default_nettype wire

@@ src/gqpe_row_mem.sv @@
`default_nettype none

module gqpe_row_mem #(
  parameter int DEPTH = gqpe_pkg::MAX_VARS_DEF,
  parameter int WIDTH = 32,
  parameter int AW    = 5
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             clr,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] valid;
  logic [WIDTH-1:0] rd_raw;
  logic             rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_raw <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (clr) begin
        valid <= '0;
      end else if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= valid[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

`default_nettype wire

@@ src/gf2_quadratic_poly_engine_core.sv @@
// Evaluate reads min(n,32) rows and substitute reads n rows, n = active count;
// add-row passes through a write state only when the row is in range.
// One transaction at a time, the next one accepted as the response rises;
// rows stream one per cycle.
// Reset: synchronous; clears row valid flags, constant and count at once,
// so rows read as zero with no clearing pass.
`default_nettype none

module gf2_quadratic_poly_engine_core #(
  parameter int MAX_VARS = gqpe_pkg::MAX_VARS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  output logic                     req_ready,
  input  wire gqpe_pkg::req_item_t req,
  output logic                     rsp_valid,
  input  wire logic                rsp_ready,
  output gqpe_pkg::rsp_item_t      rsp
);

  localparam int ROW_W    = (MAX_VARS > 32) ? MAX_VARS : 32;
  localparam int AW       = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
  localparam int CW       = $clog2(MAX_VARS + 1);
  localparam int EVAL_LIM = (MAX_VARS < 32) ? MAX_VARS : 32;

  function automatic logic [ROW_W-1:0] low_mask(input logic [CW-1:0] bits);
    logic [ROW_W-1:0] m;
    if (int'(bits) >= ROW_W) begin
      m = '1;
    end else begin
      m = (ROW_W'(1) << bits) - ROW_W'(1);
    end
    return m;
  endfunction

  gqpe_pkg::state_t    state, state_next;
  gqpe_pkg::req_item_t req_q;
  logic [CW-1:0]       cnt;
  logic                const_q;
  logic [CW-1:0]       issue;
  logic [CW-1:0]       lim;
  logic                p_vld;
  logic [AW-1:0]       p_idx;
  logic                acc;
  logic [ROW_W-1:0]    zs;
  logic [ROW_W-1:0]    keep;
  logic [CW-1:0]       m_q;

  logic                accept;
  logic [CW-1:0]       vc_sat, k_in, m_in, lim_eval;
  logic [ROW_W-1:0]    zs_in;
  logic                add_hit;

  logic                mem_clr, mem_rd_en, mem_wr_en;
  logic [AW-1:0]       mem_rd_addr, mem_wr_addr;
  logic [ROW_W-1:0]    mem_wr_data, row;

  logic [ROW_W-1:0]    point_ext;
  logic                par_eval, par_sub, low_row, const_flip;
  logic [ROW_W-1:0]    sub_wdata;

  gqpe_row_mem #(
    .DEPTH (MAX_VARS),
    .WIDTH (ROW_W),
    .AW    (AW)
  ) u_rows (
    .clk     (clk),
    .rst     (rst),
    .clr     (mem_clr),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (row),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  assign accept = req_valid && req_ready;

  assign vc_sat   = (req.var_count > 7'(MAX_VARS)) ? CW'(MAX_VARS) : CW'(req.var_count);
  assign k_in     = (7'(req.sub_count) > 7'(cnt)) ? cnt : CW'(req.sub_count);
  assign m_in     = cnt - k_in;
  assign zs_in    = (ROW_W'(req.point) & low_mask(k_in)) << m_in;
  assign lim_eval = (cnt > CW'(EVAL_LIM)) ? CW'(EVAL_LIM) : cnt;
  assign add_hit  = 7'(req.row_index) < 7'(cnt);

  assign point_ext  = ROW_W'(req_q.point);
  assign par_eval   = ^(row & point_ext);
  assign par_sub    = ^(row & zs);
  assign low_row    = CW'(p_idx) < m_q;
  assign sub_wdata  = (row ^ (ROW_W'(par_sub && low_row) << p_idx)) & keep;
  assign const_flip = p_vld && (req_q.req_type == gqpe_pkg::REQ_SUB) && !low_row
                      && par_sub && zs[p_idx];

  always_comb begin
    state_next = state;
    case (state)
      gqpe_pkg::S_IDLE: begin
        if (accept) begin
          case (req.req_type)
            gqpe_pkg::REQ_ADD:  state_next = add_hit ? gqpe_pkg::S_ADD : gqpe_pkg::S_DONE;
            gqpe_pkg::REQ_EVAL: state_next = gqpe_pkg::S_RUN;
            gqpe_pkg::REQ_SUB:  state_next = gqpe_pkg::S_RUN;
            default:            state_next = gqpe_pkg::S_DONE;
          endcase
        end
      end
      gqpe_pkg::S_ADD: state_next = gqpe_pkg::S_DONE;
      gqpe_pkg::S_RUN: begin
        if (issue >= lim) begin
          state_next = gqpe_pkg::S_DONE;
        end
      end
      gqpe_pkg::S_DONE: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = gqpe_pkg::S_IDLE;
        end
      end
      default: state_next = gqpe_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready   = 1'b0;
    mem_clr     = 1'b0;
    mem_rd_en   = 1'b0;
    mem_rd_addr = issue[AW-1:0];
    mem_wr_en   = 1'b0;
    mem_wr_addr = p_idx;
    mem_wr_data = sub_wdata;
    case (state)
      gqpe_pkg::S_IDLE: begin
        req_ready   = 1'b1;
        mem_rd_addr = AW'(req.row_index);
        if (req_valid) begin
          mem_rd_en = (req.req_type == gqpe_pkg::REQ_ADD) && add_hit;
          mem_clr   = req.req_type == gqpe_pkg::REQ_START;
        end
      end
      gqpe_pkg::S_ADD: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = AW'(req_q.row_index);
        mem_wr_data = row ^ ROW_W'(req_q.row_bits);
      end
      gqpe_pkg::S_RUN: begin
        mem_rd_en = issue < lim;
        mem_wr_en = p_vld && (req_q.req_type == gqpe_pkg::REQ_SUB);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= gqpe_pkg::S_IDLE;
      cnt       <= '0;
      const_q   <= 1'b0;
      issue     <= '0;
      lim       <= '0;
      p_vld     <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        issue <= '0;
        p_vld <= 1'b0;
        case (req.req_type)
          gqpe_pkg::REQ_START: begin
            cnt     <= vc_sat;
            const_q <= req.const_bit;
          end
          gqpe_pkg::REQ_ADD:  const_q <= const_q ^ req.const_bit;
          gqpe_pkg::REQ_EVAL: lim <= lim_eval;
          gqpe_pkg::REQ_SUB: begin
            lim <= cnt;
            cnt <= m_in;
          end
          default: begin
          end
        endcase
      end
      if (state == gqpe_pkg::S_RUN) begin
        if (mem_rd_en) begin
          issue <= issue + CW'(1);
        end
        p_vld <= mem_rd_en;
        if (const_flip) begin
          const_q <= ~const_q;
        end
      end
      if ((state == gqpe_pkg::S_DONE) && (!rsp_valid || rsp_ready)) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_q <= req;
      acc   <= 1'b0;
      if (req.req_type == gqpe_pkg::REQ_SUB) begin
        m_q  <= m_in;
        zs   <= zs_in;
        keep <= low_mask(m_in);
      end
    end
    if (state == gqpe_pkg::S_RUN) begin
      p_idx <= issue[AW-1:0];
      if (p_vld && (req_q.req_type == gqpe_pkg::REQ_EVAL) && point_ext[p_idx]) begin
        acc <= acc ^ par_eval;
      end
    end
    if ((state == gqpe_pkg::S_DONE) && (!rsp_valid || rsp_ready)) begin
      rsp.eval_value  <= (req_q.req_type == gqpe_pkg::REQ_EVAL) ? (acc ^ const_q) : 1'b0;
      rsp.active_vars <= 6'(cnt);
    end
  end

  a_issue_bound: assert property (@(posedge clk) disable iff (rst)
    (state == gqpe_pkg::S_RUN) |-> (issue <= lim))
    else $error("row issue ran past its limit");

  a_write_source: assert property (@(posedge clk) disable iff (rst)
    mem_wr_en |-> ((state == gqpe_pkg::S_ADD) ||
                   ((state == gqpe_pkg::S_RUN) && (req_q.req_type == gqpe_pkg::REQ_SUB))))
    else $error("row write outside add or substitute");

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    (cnt <= CW'(MAX_VARS)))
    else $error("active count above capacity");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == gqpe_pkg::S_DONE))
    else $error("response raised outside completion");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state == gqpe_pkg::S_RUN) |=> !$past(accept))
    else $error("transaction accepted while busy");

endmodule

`default_nettype wire

@@ bench/gf2_quadratic_poly_engine_core_tb.sv @@
module gf2_quadratic_poly_engine_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_VARS = gqpe_pkg::MAX_VARS_DEF;
  localparam int STALL_LIMIT = 3000;
  localparam int TARGET_ITEMS = 1050;

  class poly_scoreboard;
    logic [31:0]         rows [NUM_VARS];
    logic                cterm;
    int unsigned         nvars;
    gqpe_pkg::rsp_item_t pending_rsp [$];
    int unsigned         mismatches;
    int unsigned         op_counts [4];

    function new();
      foreach (rows[i]) rows[i] = '0;
      cterm = 1'b0;
      nvars = 0;
      mismatches = 0;
      foreach (op_counts[i]) op_counts[i] = 0;
    endfunction

    function void note_request(gqpe_pkg::req_item_t item);
      gqpe_pkg::rsp_item_t exp_rsp;
      logic                value;
      logic [63:0]         z;
      logic [63:0]         keep;
      logic [63:0]         high;
      int unsigned         k;
      int unsigned         m;
      value = 1'b0;
      op_counts[item.req_type]++;
      case (item.req_type)
        gqpe_pkg::REQ_START: begin
          foreach (rows[i]) rows[i] = '0;
          cterm = item.const_bit;
          nvars = (item.var_count > NUM_VARS) ? NUM_VARS : item.var_count;
        end
        gqpe_pkg::REQ_ADD: begin
          if (item.row_index < nvars) rows[item.row_index] ^= item.row_bits;
          cterm ^= item.const_bit;
        end
        gqpe_pkg::REQ_EVAL: begin
          value = cterm;
          for (int i = 0; i < nvars; i++) begin
            if (item.point[i]) value ^= ^(rows[i] & item.point);
          end
        end
        default: begin
          k = (item.sub_count > nvars) ? nvars : item.sub_count;
          m = nvars - k;
          z = {32'b0, item.point} & ((64'd1 << k) - 64'd1);
          keep = (64'd1 << m) - 64'd1;
          for (int i = 0; i < nvars; i++) begin
            high = {32'b0, rows[i]} >> m;
            if (^(high & z)) begin
              if (i < m) rows[i] ^= 32'd1 << i;
              else if (z[i - m]) cterm = ~cterm;
            end
            rows[i] &= keep[31:0];
          end
          nvars = m;
        end
      endcase
      exp_rsp.eval_value = value;
      exp_rsp.active_vars = nvars[5:0];
      pending_rsp.push_back(exp_rsp);
    endfunction

    function void check_response(gqpe_pkg::rsp_item_t got);
      gqpe_pkg::rsp_item_t exp_rsp;
      if (pending_rsp.size() == 0) begin
        $error("unexpected transaction: eval_value=%0d active_vars=%0d",
               got.eval_value, got.active_vars);
        mismatches++;
        return;
      end
      exp_rsp = pending_rsp.pop_front();
      if (got.eval_value !== exp_rsp.eval_value) begin
        $error("eval_value: expected %0d, actual %0d", exp_rsp.eval_value, got.eval_value);
        mismatches++;
      end
      if (got.active_vars !== exp_rsp.active_vars) begin
        $error("active_vars: expected %0d, actual %0d",
               exp_rsp.active_vars, got.active_vars);
        mismatches++;
      end
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_ready;
  gqpe_pkg::req_item_t req = '0;
  logic                rsp_valid;
  logic                rsp_ready = 1'b0;
  gqpe_pkg::rsp_item_t rsp;

  logic        steady = 1'b0;
  int unsigned items_sent = 0;
  int unsigned stall_cycles = 0;

  poly_scoreboard sb = new();

  gf2_quadratic_poly_engine_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    rsp_ready <= steady || ($urandom_range(0, 99) >= 14);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req_valid && req_ready) sb.note_request(req);
      if (rsp_valid && rsp_ready) sb.check_response(rsp);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic gqpe_pkg::req_item_t random_request();
    gqpe_pkg::req_item_t item;
    item.req_type = gqpe_pkg::req_t'(2'($urandom_range(0, 3)));
    item.row_index = 5'($urandom_range(0, 31));
    item.row_bits = $urandom;
    item.const_bit = 1'($urandom_range(0, 1));
    item.var_count = 7'($urandom_range(0, 127));
    item.point = $urandom;
    item.sub_count = 6'($urandom_range(0, 63));
    return item;
  endfunction

  function automatic gqpe_pkg::req_item_t make_req(gqpe_pkg::req_t op, logic [4:0] row,
                                                   logic [31:0] bits, logic cbit,
                                                   logic [6:0] vcount, logic [31:0] pt,
                                                   logic [5:0] scount);
    gqpe_pkg::req_item_t item;
    item.req_type = op;
    item.row_index = row;
    item.row_bits = bits;
    item.const_bit = cbit;
    item.var_count = vcount;
    item.point = pt;
    item.sub_count = scount;
    return item;
  endfunction

  task automatic send_request(input gqpe_pkg::req_item_t item);
    while (!steady && $urandom_range(0, 99) < 14) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_rsp.size() != 0) @(posedge clk);
  endtask

  task automatic run_poly_session();
    gqpe_pkg::req_item_t item;
    int unsigned         n;
    int unsigned         lim;
    int unsigned         pick;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 32);
    lim = (n > NUM_VARS) ? NUM_VARS : n;
    item = random_request();
    item.req_type = gqpe_pkg::REQ_START;
    item.var_count = n[6:0];
    send_request(item);
    repeat ($urandom_range(2, 12)) begin
      item = random_request();
      item.req_type = gqpe_pkg::REQ_ADD;
      if (lim != 0 && $urandom_range(0, 9) != 0) begin
        item.row_index = 5'($urandom_range(0, lim - 1));
      end
      send_request(item);
    end
    repeat ($urandom_range(3, 12)) begin
      item = random_request();
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        item.req_type = gqpe_pkg::REQ_EVAL;
      end else if (pick < 85) begin
        item.req_type = gqpe_pkg::REQ_SUB;
        if ($urandom_range(0, 7) != 0) item.sub_count = 6'($urandom_range(0, 4));
      end else begin
        item.req_type = gqpe_pkg::REQ_ADD;
      end
      send_request(item);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    send_request(make_req(gqpe_pkg::REQ_EVAL, 5'd0, 32'h0, 1'b0, 7'd0, '1, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_START, 5'd0, '1, 1'b1, 7'd127, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_EVAL, 5'd0, 32'h0, 1'b0, 7'd0, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_START, 5'd0, 32'h0, 1'b0, 7'd33, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_START, 5'd0, 32'h0, 1'b0, 7'd64, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_START, 5'd0, 32'h0, 1'b1, 7'd32, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_ADD, 5'd0, '1, 1'b1, 7'd0, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_ADD, 5'd31, '1, 1'b0, 7'd0, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_ADD, 5'd17, 32'h0001_FFFF, 1'b1, 7'd0, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_EVAL, 5'd0, 32'h0, 1'b0, 7'd0, '1, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_EVAL, 5'd0, 32'h0, 1'b0, 7'd0, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_EVAL, 5'd0, 32'h0, 1'b0, 7'd0, 32'hAAAA_AAAA, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_SUB, 5'd0, 32'h0, 1'b0, 7'd0, '1, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_SUB, 5'd0, 32'h0, 1'b0, 7'd0, 32'hFFFF_FFF5, 6'd3));
    send_request(make_req(gqpe_pkg::REQ_EVAL, 5'd0, 32'h0, 1'b0, 7'd0, '1, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_START, 5'd0, 32'h0, 1'b0, 7'd5, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_ADD, 5'd7, '1, 1'b1, 7'd0, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_ADD, 5'd4, '1, 1'b0, 7'd0, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_ADD, 5'd1, 32'h8000_0003, 1'b0, 7'd0, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_EVAL, 5'd0, 32'h0, 1'b0, 7'd0, '1, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_SUB, 5'd0, 32'h0, 1'b0, 7'd0, '1, 6'd63));
    send_request(make_req(gqpe_pkg::REQ_EVAL, 5'd0, 32'h0, 1'b0, 7'd0, '1, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_START, 5'd0, 32'h0, 1'b1, 7'd0, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_ADD, 5'd0, '1, 1'b1, 7'd0, 32'h0, 6'd0));
    send_request(make_req(gqpe_pkg::REQ_SUB, 5'd0, 32'h0, 1'b0, 7'd0, '1, 6'd2));

    wait_drained();

    while (items_sent < TARGET_ITEMS) begin
      steady <= (items_sent >= 400 && items_sent < 550);
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 5)) send_request(random_request());
      end else begin
        run_poly_session();
      end
      if (items_sent >= 700 && items_sent < 720) wait_drained();
    end

    wait_drained();
    repeat (40) @(posedge clk);

    $display("Checked %0d transactions: %0d starts, %0d row updates, %0d evaluations,",
             items_sent, sb.op_counts[gqpe_pkg::REQ_START], sb.op_counts[gqpe_pkg::REQ_ADD],
             sb.op_counts[gqpe_pkg::REQ_EVAL]);
    $display("%0d substitutions, with saturated counts and clamped substitution sizes",
             sb.op_counts[gqpe_pkg::REQ_SUB]);
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
